>>> design/mst_pkg.sv
// ----------------------------------------------------------------------------
// mst_pkg - shared types and constants
// sizes, record layouts and status codes of the spanning tree engine
// ----------------------------------------------------------------------------
package mst_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int MAX_EDGES    = 256;
  localparam int COST_BITS    = 16;

  localparam int VIDX_W = $clog2(MAX_VERTICES);
  localparam int VCNT_W = VIDX_W + 1;
  localparam int EIDX_W = $clog2(MAX_EDGES);
  localparam int ECNT_W = EIDX_W + 1;

  localparam logic [COST_BITS-1:0] COST_INF = '1;

  typedef struct packed {
    logic [VIDX_W-1:0]    from_v;
    logic [VIDX_W-1:0]    to_v;
    logic [COST_BITS-1:0] cost;
  } edge_rec_t;

  typedef struct packed {
    logic [COST_BITS-1:0] cost;
    logic [EIDX_W-1:0]    edge_idx;
  } vrec_t;

  localparam int EDGE_REC_W = $bits(edge_rec_t);
  localparam int VREC_W     = $bits(vrec_t);

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_BAD_START = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_DISCONN   = 3'd4
  } status_t;

  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_START_VERTEX = 1'b1;

endpackage

>>> design/mst_ram.sv
// ----------------------------------------------------------------------------
// mst_ram - generic single port ram
// one read or write per cycle, registered read data
// ----------------------------------------------------------------------------
module mst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> design/prim_minimum_spanning_tree_top.sv
// ----------------------------------------------------------------------------
// prim_minimum_spanning_tree_top - prim spanning tree engine
// loads directed edges, then grows a tree from the start vertex
// ----------------------------------------------------------------------------
// Edges load one beat per cycle while busy is low. The beat with in_last_edge
// set is stored too and starts the search; busy stays high until the run is
// over. Tree edges come out in the order they join the tree, one out_valid
// strobe each, and the receiver cannot stall them; the last beat of a run
// carries out_last_result. A bad start, an edge overflow or a one vertex graph
// give one status beat only; a disconnected graph gives the edges found and
// then a status beat. The search walks edges out of one ram and per vertex
// cost/edge out of a second ram: each round scans all n vertices, emits the
// picked vertex's tree edge (none for the start vertex), then, unless that
// was the last edge, walks all E stored edges, with an extra vertex ram step
// when the edge leaves the picked vertex toward an unreached vertex in range.
// Run time is set by these serial ram walks.
// ----------------------------------------------------------------------------
module prim_minimum_spanning_tree_top
  import mst_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [VIDX_W-1:0]    in_edge_from,
  input  logic [VIDX_W-1:0]    in_edge_to,
  input  logic [COST_BITS-1:0] in_edge_cost,
  input  logic                 in_last_edge,
  output logic                 out_valid,
  output logic [VIDX_W-1:0]    out_tree_from,
  output logic [VIDX_W-1:0]    out_tree_to,
  output logic [COST_BITS-1:0] out_tree_cost,
  output logic [2:0]           out_status,
  output logic                 out_last_result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_SEL, S_PICK, S_EMIT, S_RE, S_RV, S_RW
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [5:0]        vcount_r;
  logic [VIDX_W-1:0] svert_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_VERTEX_COUNT: prdata[5:0]        = vcount_r;
      REG_START_VERTEX: prdata[VIDX_W-1:0] = svert_r;
      default: prdata = '0;
    endcase
  end

  // run state
  logic [ECNT_W-1:0]       etotal_r, etotal_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [MAX_VERTICES-1:0] reached_r, reached_nxt;
  logic [MAX_VERTICES-1:0] bvalid_r, bvalid_nxt;    // vertex ram entry written
  logic [VCNT_W-1:0]       scan_r, scan_nxt;
  logic                    cmp_vld_r, cmp_vld_nxt;
  logic [VIDX_W-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic [COST_BITS-1:0]    low_r, low_nxt;
  logic [VCNT_W-1:0]       pick_r, pick_nxt;
  logic [EIDX_W-1:0]       pedge_r, pedge_nxt;
  logic [VCNT_W-1:0]       round_r, round_nxt;
  logic [ECNT_W-1:0]       eidx_r, eidx_nxt;
  edge_rec_t               cur_r, cur_nxt;

  // registered result beat
  logic                 ov_r, ov_nxt;
  logic [VIDX_W-1:0]    of_r, of_nxt;
  logic [VIDX_W-1:0]    ot_r, ot_nxt;
  logic [COST_BITS-1:0] oc_r, oc_nxt;
  logic [2:0]           os_r, os_nxt;
  logic                 ol_r, ol_nxt;

  // rams
  logic              e_we;
  logic [EIDX_W-1:0] e_addr;
  edge_rec_t         e_wdata, e_rdata;
  logic              v_we;
  logic [VIDX_W-1:0] v_addr;
  vrec_t             v_wdata, v_rdata;

  mst_ram #(.WIDTH(EDGE_REC_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk(clk), .we(e_we), .addr(e_addr), .wdata(e_wdata), .rdata(e_rdata)
  );

  mst_ram #(.WIDTH(VREC_W), .DEPTH(MAX_VERTICES)) u_vert_ram (
    .clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wdata), .rdata(v_rdata)
  );

  // effective vertex count
  logic [VCNT_W-1:0] n_eff;
  assign n_eff = (vcount_r >= 6'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES)
                                                : VCNT_W'(vcount_r);

  logic [COST_BITS-1:0] cmp_cost, rw_cost;
  assign cmp_cost = bvalid_r[cmp_idx_r] ? v_rdata.cost : COST_INF;
  assign rw_cost  = bvalid_r[cur_r.to_v] ? v_rdata.cost : COST_INF;

  always_comb begin
    state_nxt   = state_r;
    etotal_nxt  = etotal_r;
    ovf_nxt     = ovf_r;
    reached_nxt = reached_r;
    bvalid_nxt  = bvalid_r;
    scan_nxt    = scan_r;
    cmp_vld_nxt = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    low_nxt     = low_r;
    pick_nxt    = pick_r;
    pedge_nxt   = pedge_r;
    round_nxt   = round_r;
    eidx_nxt    = eidx_r;
    cur_nxt     = cur_r;
    ov_nxt      = 1'b0;
    of_nxt      = '0;
    ot_nxt      = '0;
    oc_nxt      = '0;
    os_nxt      = ST_OK;
    ol_nxt      = 1'b0;
    e_we        = 1'b0;
    e_addr      = etotal_r[EIDX_W-1:0];
    e_wdata     = '{from_v: in_edge_from, to_v: in_edge_to, cost: in_edge_cost};
    v_we        = 1'b0;
    v_addr      = scan_r[VIDX_W-1:0];
    v_wdata     = '{cost: '0, edge_idx: '0};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (etotal_r < ECNT_W'(MAX_EDGES)) begin
            e_we       = 1'b1;
            etotal_nxt = etotal_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_edge) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (n_eff == '0 || VCNT_W'(svert_r) >= n_eff) begin
          ov_nxt = 1'b1; os_nxt = ST_BAD_START; ol_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (ovf_r) begin
          ov_nxt = 1'b1; os_nxt = ST_OVERFLOW; ol_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (n_eff == VCNT_W'(1)) begin
          ov_nxt = 1'b1; os_nxt = ST_EMPTY; ol_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          // start vertex gets cost zero
          v_we   = 1'b1;
          v_addr = svert_r;
          bvalid_nxt[svert_r] = 1'b1;
          round_nxt = '0;
          scan_nxt  = '0;
          low_nxt   = COST_INF;
          pick_nxt  = n_eff;
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        // issue one vertex read a cycle, compare it in the cycle after
        if (scan_r < n_eff) begin
          v_addr      = scan_r[VIDX_W-1:0];
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = scan_r[VIDX_W-1:0];
          scan_nxt    = scan_r + 1'b1;
        end else begin
          state_nxt = S_PICK;
        end
        if (cmp_vld_r && !reached_r[cmp_idx_r] && cmp_cost < low_r) begin
          low_nxt   = cmp_cost;
          pick_nxt  = VCNT_W'(cmp_idx_r);
          pedge_nxt = v_rdata.edge_idx;
        end
      end
      S_PICK: begin
        if (pick_r == n_eff) begin
          ov_nxt = 1'b1; os_nxt = ST_DISCONN; ol_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          reached_nxt[pick_r[VIDX_W-1:0]] = 1'b1;
          eidx_nxt = '0;
          if (pick_r == VCNT_W'(svert_r)) begin
            state_nxt = S_RE;
          end else begin
            e_addr    = pedge_r;
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        ov_nxt = 1'b1;
        of_nxt = e_rdata.from_v;
        ot_nxt = e_rdata.to_v;
        oc_nxt = e_rdata.cost;
        os_nxt = ST_OK;
        if (round_r == n_eff - 1'b1) begin
          ol_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_RE;
        end
      end
      S_RE: begin
        if (eidx_r == etotal_r) begin
          round_nxt = round_r + 1'b1;
          scan_nxt  = '0;
          low_nxt   = COST_INF;
          pick_nxt  = n_eff;
          state_nxt = S_SEL;
        end else begin
          e_addr    = eidx_r[EIDX_W-1:0];
          state_nxt = S_RV;
        end
      end
      S_RV: begin
        cur_nxt = e_rdata;
        if (VCNT_W'(e_rdata.from_v) == pick_r && VCNT_W'(e_rdata.to_v) < n_eff &&
            !reached_r[e_rdata.to_v]) begin
          v_addr    = e_rdata.to_v;
          state_nxt = S_RW;
        end else begin
          eidx_nxt  = eidx_r + 1'b1;
          state_nxt = S_RE;
        end
      end
      S_RW: begin
        v_addr = cur_r.to_v;
        if (cur_r.cost < rw_cost) begin
          v_we    = 1'b1;
          v_wdata = '{cost: cur_r.cost, edge_idx: eidx_r[EIDX_W-1:0]};
          bvalid_nxt[cur_r.to_v] = 1'b1;
        end
        eidx_nxt  = eidx_r + 1'b1;
        state_nxt = S_RE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // end of run clears the graph for the next load
    if (ol_nxt) begin
      etotal_nxt  = '0;
      ovf_nxt     = 1'b0;
      reached_nxt = '0;
      bvalid_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      vcount_r  <= 6'd32;
      svert_r   <= '0;
      etotal_r  <= '0;
      ovf_r     <= 1'b0;
      reached_r <= '0;
      bvalid_r  <= '0;
      cmp_vld_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      etotal_r  <= etotal_nxt;
      ovf_r     <= ovf_nxt;
      reached_r <= reached_nxt;
      bvalid_r  <= bvalid_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      ov_r      <= ov_nxt;
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_VERTEX_COUNT: vcount_r <= pwdata[5:0];
          REG_START_VERTEX: svert_r  <= pwdata[VIDX_W-1:0];
          default: ;
        endcase
      end
    end
    scan_r    <= scan_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    low_r     <= low_nxt;
    pick_r    <= pick_nxt;
    pedge_r   <= pedge_nxt;
    round_r   <= round_nxt;
    eidx_r    <= eidx_nxt;
    cur_r     <= cur_nxt;
    of_r      <= of_nxt;
    ot_r      <= ot_nxt;
    oc_r      <= oc_nxt;
    os_r      <= os_nxt;
    ol_r      <= ol_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = ov_r;
  assign out_tree_from   = of_r;
  assign out_tree_to     = ot_r;
  assign out_tree_cost   = oc_r;
  assign out_status      = os_r;
  assign out_last_result = ol_r;

`ifndef SYNTHESIS
  // the final beat of a run is never followed right away by another
  a_last_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |=> !out_valid)
    else $error("result beat right after final beat");

  // a status beat always ends the run
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last_result)
    else $error("status beat not final");

  // a plain edge load keeps the block ready
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_last_edge |=> !busy)
    else $error("busy after plain edge load");
`endif

endmodule

>>> tb/mst_checker.sv
// ----------------------------------------------------------------------------
// mst_checker - spanning tree result checker
// watches the edge, result and register ports, predicts each run's tree beats
// and compares every result beat field by field against the oldest prediction
// ----------------------------------------------------------------------------
module mst_checker
  import mst_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [VIDX_W-1:0]    in_edge_from,
  input  logic [VIDX_W-1:0]    in_edge_to,
  input  logic [COST_BITS-1:0] in_edge_cost,
  input  logic                 in_last_edge,
  input  logic                 out_valid,
  input  logic [VIDX_W-1:0]    out_tree_from,
  input  logic [VIDX_W-1:0]    out_tree_to,
  input  logic [COST_BITS-1:0] out_tree_cost,
  input  logic [2:0]           out_status,
  input  logic                 out_last_result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  input  logic                 pready,
  output int                   failures,
  output int                   pending
);

  typedef struct {
    logic [VIDX_W-1:0]    from_v;
    logic [VIDX_W-1:0]    to_v;
    logic [COST_BITS-1:0] cost;
    logic [2:0]           status;
    logic                 last;
  } tree_beat_t;

  tree_beat_t           tree_q[$];
  edge_rec_t            graph_edges[MAX_EDGES];
  int                   graph_size;
  logic                 dropped_edge;
  logic [COST_BITS-1:0] best_cost[MAX_VERTICES];
  int                   best_link[MAX_VERTICES];
  logic                 in_tree[MAX_VERTICES];
  logic [VCNT_W-1:0]    vcount_reg;
  logic [VIDX_W-1:0]    root_reg;

  function automatic void clear_graph();
    graph_size   = 0;
    dropped_edge = 1'b0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      best_cost[i] = COST_INF;
      best_link[i] = 0;
      in_tree[i]   = 1'b0;
    end
  endfunction

  function automatic void push_beat(logic [VIDX_W-1:0] f, logic [VIDX_W-1:0] t,
                                    logic [COST_BITS-1:0] c, status_t st);
    tree_beat_t b;
    b.from_v = f;
    b.to_v   = t;
    b.cost   = c;
    b.status = st;
    b.last   = 1'b0;
    tree_q.push_back(b);
  endfunction

  // prim growth over the stored graph, appends this run's beats
  function automatic void grow_tree();
    int n, root, pick, first;
    logic [COST_BITS-1:0] low;
    logic done;
    edge_rec_t ed;
    n     = (vcount_reg > MAX_VERTICES) ? MAX_VERTICES : int'(vcount_reg);
    root  = int'(root_reg);
    first = tree_q.size();
    if (n == 0 || root >= n) begin
      push_beat('0, '0, '0, ST_BAD_START);
    end else if (dropped_edge) begin
      push_beat('0, '0, '0, ST_OVERFLOW);
    end else if (n == 1) begin
      push_beat('0, '0, '0, ST_EMPTY);
    end else begin
      best_cost[root] = '0;
      done = 1'b0;
      for (int r = 0; r < n && !done; r++) begin
        pick = n;
        low  = COST_INF;
        // strict compare keeps the lowest index on ties
        for (int i = 0; i < n; i++) begin
          if (!in_tree[i] && best_cost[i] < low) begin
            low  = best_cost[i];
            pick = i;
          end
        end
        if (pick >= n) begin
          push_beat('0, '0, '0, ST_DISCONN);
          done = 1'b1;
        end else begin
          in_tree[pick] = 1'b1;
          if (pick != root) begin
            ed = graph_edges[best_link[pick]];
            push_beat(ed.from_v, ed.to_v, ed.cost, ST_OK);
          end
          for (int e = 0; e < graph_size; e++) begin
            ed = graph_edges[e];
            if (int'(ed.from_v) == pick && int'(ed.to_v) < n) begin
              if (!in_tree[ed.to_v] && ed.cost < best_cost[ed.to_v]) begin
                best_cost[ed.to_v] = ed.cost;
                best_link[ed.to_v] = e;
              end
            end
          end
        end
      end
    end
    if (tree_q.size() > first) tree_q[tree_q.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    tree_beat_t exp_b;
    if (!rst_n) begin
      tree_q.delete();
      clear_graph();
      vcount_reg = 6'd32;
      root_reg   = '0;
      failures   = 0;
    end else begin
      // result side first: a beat on this edge never belongs to this edge's item
      if (out_valid) begin
        if (tree_q.size() == 0) begin
          $error("tree beat with nothing expected: from %0d to %0d cost %0d status %0d",
                 out_tree_from, out_tree_to, out_tree_cost, out_status);
          failures++;
        end else begin
          exp_b = tree_q.pop_front();
          if (out_tree_from !== exp_b.from_v) begin
            $error("tree_from expected %0d actual %0d", exp_b.from_v, out_tree_from);
            failures++;
          end
          if (out_tree_to !== exp_b.to_v) begin
            $error("tree_to expected %0d actual %0d", exp_b.to_v, out_tree_to);
            failures++;
          end
          if (out_tree_cost !== exp_b.cost) begin
            $error("tree_cost expected %0d actual %0d", exp_b.cost, out_tree_cost);
            failures++;
          end
          if (out_status !== exp_b.status) begin
            $error("status expected %0d actual %0d", exp_b.status, out_status);
            failures++;
          end
          if (out_last_result !== exp_b.last) begin
            $error("last_result expected %0d actual %0d", exp_b.last, out_last_result);
            failures++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_VERTEX_COUNT) vcount_reg = pwdata[VCNT_W-1:0];
        else                              root_reg   = pwdata[VIDX_W-1:0];
      end
      if (start && !busy) begin
        if (graph_size < MAX_EDGES) begin
          graph_edges[graph_size] = '{from_v: in_edge_from, to_v: in_edge_to,
                                      cost: in_edge_cost};
          graph_size++;
        end else begin
          dropped_edge = 1'b1;
        end
        if (in_last_edge) begin
          grow_tree();
          clear_graph();
        end
      end
    end
    pending = tree_q.size();
  end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb - spanning tree engine testbench
// loads directed and random graphs with random gaps and register settings;
// the checker beside the block predicts and compares every tree beat
// ----------------------------------------------------------------------------
module tb;
  import mst_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [VIDX_W-1:0]    in_edge_from = '0;
  logic [VIDX_W-1:0]    in_edge_to = '0;
  logic [COST_BITS-1:0] in_edge_cost = '0;
  logic                 in_last_edge = 1'b0;
  logic                 out_valid;
  logic [VIDX_W-1:0]    out_tree_from;
  logic [VIDX_W-1:0]    out_tree_to;
  logic [COST_BITS-1:0] out_tree_cost;
  logic [2:0]           out_status;
  logic                 out_last_result;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [2:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;
  int                   failures;
  int                   pending;
  int                   edges_sent;

  localparam logic [2:0] ADDR_VCOUNT = 3'd0;
  localparam logic [2:0] ADDR_ROOT   = 3'd4;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  prim_minimum_spanning_tree_top dut (.*);

  mst_checker u_checker (.*);

  // watchdog: far beyond the slowest legal run
  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

  // one register write: setup then access, completes when pready is seen
  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // drop start, wait for every predicted beat and for the search to wind down
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_graph(int vcount, int root);
    write_reg(ADDR_VCOUNT, vcount);
    write_reg(ADDR_ROOT, root);
  endtask

  // one edge beat; start stays high straight through back to back beats
  task automatic send_edge(int f, int t, int c, bit last, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_edge_from <= VIDX_W'(f);
    in_edge_to   <= VIDX_W'(t);
    in_edge_cost <= COST_BITS'(c);
    in_last_edge <= last;
    do @(posedge clk); while (busy);
    edges_sent++;
  endtask

  initial begin
    int n, root, k, f, t, c, gap_mode, gap;
    edges_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ties, infinite cost, a later cheaper edge, an out of range target
    set_graph(4, 0);
    send_edge(0, 1, 5, 0, 0);
    send_edge(0, 2, 5, 0, 0);
    send_edge(1, 3, 16'hFFFF, 0, 1);
    send_edge(2, 3, 0, 0, 0);
    send_edge(3, 1, 0, 0, 2);
    send_edge(0, 9, 1, 0, 0);
    send_edge(2, 1, 16'hFFFE, 1, 0);
    wait_idle();
    // disconnected after one tree edge
    set_graph(3, 2);
    send_edge(2, 0, 1, 1, 0);
    wait_idle();
    // single vertex
    set_graph(1, 0);
    send_edge(0, 0, 7, 1, 3);
    wait_idle();
    // count clipped to the vertex limit, top start vertex
    set_graph(63, 31);
    send_edge(31, 0, 16'hFFFE, 0, 0);
    send_edge(0, 31, 3, 0, 0);
    send_edge(31, 30, 16'hFFFF, 0, 0);
    send_edge(30, 31, 0, 1, 0);
    wait_idle();
    // bad start: zero vertices, then start beyond the count
    set_graph(0, 0);
    send_edge(1, 2, 4, 1, 0);
    wait_idle();
    set_graph(5, 7);
    send_edge(7, 0, 4, 1, 1);
    wait_idle();
    // edge store overflow: one edge past the store
    set_graph(4, 0);
    for (int i = 0; i <= MAX_EDGES; i++)
      send_edge(i % 4, (i + 1) % 4, i, i == MAX_EDGES, 0);
    wait_idle();

    edges_sent = 0;
    while (edges_sent < 170) begin
      // mostly small graphs; now and then any count and any start
      if ($urandom_range(0, 7) == 0) n = $urandom_range(0, 63);
      else                           n = $urandom_range(2, 8);
      if ($urandom_range(0, 5) == 0 || n == 0) root = $urandom_range(0, 31);
      else root = $urandom_range(0, (n > 32 ? 32 : n) - 1);
      set_graph(n, root);
      k        = $urandom_range(1, 3 * ((n > 8 || n == 0) ? 8 : n));
      gap_mode = $urandom_range(0, 2);
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(0, 9) == 0 || n < 2) begin
          f = $urandom_range(0, 31);
          t = $urandom_range(0, 31);
        end else begin
          f = $urandom_range(0, (n > 32 ? 32 : n) - 1);
          t = $urandom_range(0, (n > 32 ? 32 : n) - 1);
        end
        case ($urandom_range(0, 5))
          0:       c = $urandom_range(0, 16'hFFFF);
          1:       c = 16'hFFFF;
          default: c = $urandom_range(0, 7);
        endcase
        gap = (gap_mode == 0) ? 0 : $urandom_range(0, 9);
        send_edge(f, t, c, i == k - 1, gap);
      end
      wait_idle();
    end

    // wait_idle already covered the tail of the last run
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> prim_minimum_spanning_tree_top.f
design/mst_pkg.sv
design/mst_ram.sv
design/prim_minimum_spanning_tree_top.sv
tb/mst_checker.sv
tb/tb.sv
